@@ src/smbseq_pkg.sv @@
`default_nettype none

package smbseq_pkg;

    // buffer and counter sizing
    localparam int TX_DEPTH = 16;
    localparam int RX_DEPTH = 16;
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int CNT_W    = 5;

    localparam logic [CNT_W-1:0] TX_DEPTH_C = CNT_W'(TX_DEPTH);
    localparam logic [CNT_W-1:0] RX_DEPTH_C = CNT_W'(RX_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    localparam logic [7:0] ADDR_MASK = 8'hFE;

    // op codes
    localparam logic [2:0] OP_LOAD        = 3'd0;
    localparam logic [2:0] OP_START_WRITE = 3'd1;
    localparam logic [2:0] OP_START_READ  = 3'd2;
    localparam logic [2:0] OP_STATUS      = 3'd3;
    localparam logic [2:0] OP_TIMEOUT     = 3'd4;

    // bus status kinds
    localparam logic [1:0] ST_START_SENT = 2'd0;
    localparam logic [1:0] ST_BYTE_SENT  = 2'd1;
    localparam logic [1:0] ST_BYTE_RECV  = 2'd2;
    localparam logic [1:0] ST_OTHER      = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] tx_index;
        logic [7:0] tx_byte;
        logic [7:0] slave_address;
        logic [4:0] read_count;
        logic [1:0] status_kind;
        logic       ack_in;
        logic       arb_lost;
        logic [7:0] rx_byte;
    } cmd_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_data;
        logic        start_cmd;
        logic        stop_cmd;
        logic        ack_out;
        logic        bus_reset;
        logic        rx_valid;
        logic [3:0]  rx_index;
        logic [7:0]  rx_data;
        logic        busy_res;
        logic        timed_out;
        logic [31:0] error_count;
    } res_item_t;

    typedef struct packed {
        logic             we;
        logic [TX_AW-1:0] waddr;
        logic [7:0]       wdata;
        logic [TX_AW-1:0] raddr;
    } wbuf_ctl_t;

endpackage

`default_nettype wire

@@ src/smbseq_ifs.sv @@
`default_nettype none

interface smbseq_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [3:0] tx_index;
    logic [7:0] tx_byte;
    logic [7:0] slave_address;
    logic [4:0] read_count;
    logic [1:0] status_kind;
    logic       ack_in;
    logic       arb_lost;
    logic [7:0] rx_byte;

    modport source (
        output valid, op, tx_index, tx_byte, slave_address, read_count,
               status_kind, ack_in, arb_lost, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, op, tx_index, tx_byte, slave_address, read_count,
               status_kind, ack_in, arb_lost, rx_byte,
        output ready
    );
endinterface

interface smbseq_res_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_data;
    logic        start_cmd;
    logic        stop_cmd;
    logic        ack_out;
    logic        bus_reset;
    logic        rx_valid;
    logic [3:0]  rx_index;
    logic [7:0]  rx_data;
    logic        busy_res;
    logic        timed_out;
    logic [31:0] error_count;

    modport source (
        output valid, tx_valid, tx_data, start_cmd, stop_cmd, ack_out, bus_reset,
               rx_valid, rx_index, rx_data, busy_res, timed_out, error_count,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_data, start_cmd, stop_cmd, ack_out, bus_reset,
               rx_valid, rx_index, rx_data, busy_res, timed_out, error_count,
        output ready
    );
endinterface

`default_nettype wire

@@ src/smbseq_wbuf.sv @@
`default_nettype none

module smbseq_wbuf #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    // simple RAM, registered read-first port, contents undefined until written
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/smbseq_step.sv @@
`default_nettype none

module smbseq_step
    import smbseq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire cmd_item_t        item,
    input  wire logic [CNT_W-1:0] write_length,
    input  wire logic [7:0]       buf_rdata,
    output wbuf_ctl_t             buf_ctl,
    output res_item_t             result
);

    logic             read_dir_reg,   read_dir_next;
    logic             busy_reg,       busy_next;
    logic             timeout_reg,    timeout_next;
    logic [CNT_W-1:0] sent_cnt_reg,   sent_cnt_next;
    logic [CNT_W-1:0] recv_cnt_reg,   recv_cnt_next;
    logic [CNT_W-1:0] req_bytes_reg,  req_bytes_next;
    logic [7:0]       target_reg,     target_next;
    logic [31:0]      errors_reg,     errors_next;

    // load to the slot being fetched, which the read-first RAM would not return
    logic             byp_hit_reg,    byp_hit_next;
    logic [7:0]       byp_data_reg;
    logic [7:0]       wbuf_data;

    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] sent_idx;
    logic [CNT_W-1:0] recv_idx;
    logic             fail;

    always_comb
    begin
        len      = (write_length > TX_DEPTH_C) ? TX_DEPTH_C : write_length;
        // fetch the slot the next item will see, RAM read is registered
        sent_idx = (fire ? sent_cnt_next : sent_cnt_reg) - CNT_ONE;
        recv_idx = recv_cnt_reg - CNT_ONE;
    end

    always_comb
    begin
        buf_ctl.we    = fire && (item.op == OP_LOAD) && (32'(item.tx_index) < TX_DEPTH);
        buf_ctl.waddr = TX_AW'(item.tx_index);
        buf_ctl.wdata = item.tx_byte;
        buf_ctl.raddr = sent_idx[TX_AW-1:0];
    end

    always_comb
    begin
        byp_hit_next = buf_ctl.we && (buf_ctl.waddr == buf_ctl.raddr);
        wbuf_data    = byp_hit_reg ? byp_data_reg : buf_rdata;
    end

    always_comb
    begin
        read_dir_next  = read_dir_reg;
        busy_next      = busy_reg;
        timeout_next   = timeout_reg;
        sent_cnt_next  = sent_cnt_reg;
        recv_cnt_next  = recv_cnt_reg;
        req_bytes_next = req_bytes_reg;
        target_next    = target_reg;
        errors_next    = errors_reg;
        fail           = 1'b0;

        result = '0;

        case (item.op)
            OP_START_WRITE, OP_START_READ:
            begin
                if (!busy_reg)
                begin
                    busy_next        = 1'b1;
                    read_dir_next    = (item.op == OP_START_READ);
                    target_next      = item.slave_address;
                    timeout_next     = 1'b0;
                    result.start_cmd = 1'b1;
                    if (item.op == OP_START_READ)
                    begin
                        if (item.read_count == '0)
                            req_bytes_next = CNT_ONE;
                        else if (item.read_count > RX_DEPTH_C)
                            req_bytes_next = RX_DEPTH_C;
                        else
                            req_bytes_next = item.read_count;
                    end
                end
            end
            OP_STATUS:
            begin
                if (item.arb_lost || item.status_kind == ST_OTHER)
                begin
                    fail = 1'b1;
                end
                else if (item.status_kind == ST_START_SENT)
                begin
                    result.tx_valid = 1'b1;
                    result.tx_data  = (target_reg & ADDR_MASK) | {7'd0, read_dir_reg};
                    sent_cnt_next   = CNT_ONE;
                    recv_cnt_next   = CNT_ONE;
                end
                else if (item.status_kind == ST_BYTE_SENT)
                begin
                    if (item.ack_in)
                    begin
                        if (!read_dir_reg)
                        begin
                            if (sent_cnt_reg >= CNT_ONE && sent_cnt_reg <= len)
                            begin
                                result.tx_valid = 1'b1;
                                result.tx_data  = wbuf_data;
                                sent_cnt_next   = sent_cnt_reg + CNT_ONE;
                            end
                            else
                            begin
                                result.stop_cmd = 1'b1;
                                busy_next       = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        // NACK: restart the transfer
                        result.stop_cmd  = 1'b1;
                        result.start_cmd = 1'b1;
                        errors_next      = errors_reg + 32'd1;
                    end
                end
                else
                begin
                    result.rx_valid = 1'b1;
                    result.rx_index = recv_idx[3:0];
                    result.rx_data  = item.rx_byte;
                    if (recv_cnt_reg < req_bytes_reg)
                    begin
                        result.ack_out = 1'b1;
                        recv_cnt_next  = recv_cnt_reg + CNT_ONE;
                    end
                    else
                    begin
                        result.stop_cmd = 1'b1;
                        busy_next       = 1'b0;
                    end
                end

                if (fail)
                begin
                    result.bus_reset = 1'b1;
                    result.start_cmd = 1'b0;
                    result.stop_cmd  = 1'b0;
                    result.ack_out   = 1'b0;
                    busy_next        = 1'b0;
                    errors_next      = errors_reg + 32'd1;
                end
            end
            OP_TIMEOUT:
            begin
                result.bus_reset = 1'b1;
                busy_next        = 1'b0;
                timeout_next     = 1'b1;
            end
            default:
            begin
                // loads and unused codes leave the sequencer state alone
            end
        endcase

        result.busy_res    = busy_next;
        result.timed_out   = timeout_next;
        result.error_count = errors_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_dir_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            timeout_reg   <= 1'b0;
            sent_cnt_reg  <= CNT_ONE;
            recv_cnt_reg  <= CNT_ONE;
            req_bytes_reg <= CNT_ONE;
            target_reg    <= 8'd0;
            errors_reg    <= 32'd0;
        end
        else if (fire)
        begin
            read_dir_reg  <= read_dir_next;
            busy_reg      <= busy_next;
            timeout_reg   <= timeout_next;
            sent_cnt_reg  <= sent_cnt_next;
            recv_cnt_reg  <= recv_cnt_next;
            req_bytes_reg <= req_bytes_next;
            target_reg    <= target_next;
            errors_reg    <= errors_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg  <= 1'b0;
            byp_data_reg <= 8'd0;
        end
        else
        begin
            byp_hit_reg  <= byp_hit_next;
            byp_data_reg <= buf_ctl.wdata;
        end
    end

    a_timeout_frees_bus: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op == OP_TIMEOUT |=> timeout_reg && !busy_reg)
        else $error("timeout did not free the bus");

    a_errors_only_on_status: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op != OP_STATUS |=> $stable(errors_reg))
        else $error("error count moved outside a status event");

    a_counters_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sent_cnt_reg <= TX_DEPTH_C + CNT_ONE && recv_cnt_reg <= RX_DEPTH_C)
        else $error("transfer counter out of range");

endmodule

`default_nettype wire

@@ src/smbus_master_transfer_sequencer.sv @@
// Path: a transfer accepted on cmd is held in the input register, then passes
//   through the result register before it shows on res.
// Throughput: one transfer per cycle while res does not stall; one decode/update
//   pass between the input register and the result register sets that figure.
// Reset (rst_n, async, active low): bus idle, counters at one, error count and
//   timeout flag clear, write_length one; the write buffer is not cleared.
`default_nettype none

module smbus_master_transfer_sequencer
    import smbseq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_wdata,
    smbseq_cmd_if.sink            cmd,
    smbseq_res_if.source          res
);

    // configuration: data bytes per write transfer
    logic [CNT_W-1:0] wlen_reg;

    // input stage
    logic      s1_valid_reg, s1_valid_next;
    cmd_item_t s1_item_reg;
    cmd_item_t cmd_item;

    // result stage
    logic      res_valid_reg, res_valid_next;
    res_item_t res_item_reg;
    res_item_t step_result;

    logic       adv;        // result stage can take a new item
    logic       fire;       // input stage item is processed this cycle
    wbuf_ctl_t  buf_ctl;
    logic [7:0] buf_rdata;

    always_comb
    begin
        cmd_item.op            = cmd.op;
        cmd_item.tx_index      = cmd.tx_index;
        cmd_item.tx_byte       = cmd.tx_byte;
        cmd_item.slave_address = cmd.slave_address;
        cmd_item.read_count    = cmd.read_count;
        cmd_item.status_kind   = cmd.status_kind;
        cmd_item.ack_in        = cmd.ack_in;
        cmd_item.arb_lost      = cmd.arb_lost;
        cmd_item.rx_byte       = cmd.rx_byte;
    end

    // Two-stage pipe: the input register can still take one transfer while a
    // result waits; state is updated in order as items move to the result.
    assign adv       = !res_valid_reg || res.ready;
    assign fire      = s1_valid_reg && adv;
    assign cmd.ready = !s1_valid_reg || adv;

    always_comb
    begin
        s1_valid_next  = cmd.ready ? cmd.valid : s1_valid_reg;
        res_valid_next = adv ? s1_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= CNT_ONE;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wlen_reg <= cfg_wdata;
            end
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_item_reg <= cmd_item;
        end
        if (fire)
        begin
            res_item_reg <= step_result;
        end
    end

    // write buffer; the step logic fetches the slot the next item will use
    smbseq_wbuf #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_wbuf (
        .clk   (clk),
        .we    (buf_ctl.we),
        .waddr (buf_ctl.waddr),
        .wdata (buf_ctl.wdata),
        .raddr (buf_ctl.raddr),
        .rdata (buf_rdata)
    );

    smbseq_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .item         (s1_item_reg),
        .write_length (wlen_reg),
        .buf_rdata    (buf_rdata),
        .buf_ctl      (buf_ctl),
        .result       (step_result)
    );

    assign res.valid       = res_valid_reg;
    assign res.tx_valid    = res_item_reg.tx_valid;
    assign res.tx_data     = res_item_reg.tx_data;
    assign res.start_cmd   = res_item_reg.start_cmd;
    assign res.stop_cmd    = res_item_reg.stop_cmd;
    assign res.ack_out     = res_item_reg.ack_out;
    assign res.bus_reset   = res_item_reg.bus_reset;
    assign res.rx_valid    = res_item_reg.rx_valid;
    assign res.rx_index    = res_item_reg.rx_index;
    assign res.rx_data     = res_item_reg.rx_data;
    assign res.busy_res    = res_item_reg.busy_res;
    assign res.timed_out   = res_item_reg.timed_out;
    assign res.error_count = res_item_reg.error_count;

    // a bus reset always leaves the bus free
    a_reset_frees_bus: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.bus_reset |-> !res.busy_res)
        else $error("bus reset with bus still busy");

    // a plain START only comes from an accepted start, which claims the bus
    a_start_claims_bus: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.start_cmd && !res.stop_cmd |-> res.busy_res)
        else $error("START issued without claiming the bus");

    // never send and receive in the same transfer
    a_tx_rx_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.tx_valid && res.rx_valid))
        else $error("send and receive in one result");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none

// Self-checking bench for the SMBus master transfer sequencer.
// Stimulus goes in through the cmd channel, results come back on res; every
// accepted cmd transfer is run through a local copy of the sequencer behavior
// and its outputs are queued, so each res transfer is checked against the
// oldest queued entry, field by field.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smbseq_pkg::*;

    // op codes past OP_TIMEOUT carry no function; the block only reports status
    localparam int OP_CODES = 8;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    smbseq_cmd_if cmd_bus ();
    smbseq_res_if res_bus ();

    smbus_master_transfer_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_bus),
        .res       (res_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow state of the sequencer, starting from its reset values.
    // The write buffer has no reset; the first test fills every entry, so
    // a write transfer never sends an entry that was never loaded.
    // ------------------------------------------------------------------
    logic [7:0]       wbuf_shadow [TX_DEPTH];
    logic             dir_is_read  = 1'b0;
    logic             bus_claimed  = 1'b0;
    logic             timeout_seen = 1'b0;
    logic [CNT_W-1:0] bytes_sent   = CNT_ONE;   // next buffer slot, one based
    logic [CNT_W-1:0] bytes_rcvd   = CNT_ONE;   // next read position, one based
    logic [CNT_W-1:0] bytes_wanted = CNT_ONE;
    logic [7:0]       addr_latched = 8'h00;
    logic [31:0]      err_tally    = 32'h0;
    logic [CNT_W-1:0] wr_len       = CNT_ONE;

    res_item_t awaited_outputs [$];
    int        sent_items = 0;
    int        n_fail     = 0;

    // per-side idling switches; some phases turn one or both off
    bit cmd_idle_on = 1'b1;
    bit res_idle_on = 1'b1;

    // Outputs of one bus event; updates the shadow state as the block would.
    function automatic res_item_t bus_event_outputs(input cmd_item_t c);
        res_item_t        r;
        logic [CNT_W-1:0] len;
        logic             fail;
        r    = '0;
        fail = 1'b0;
        case (c.op)
            OP_LOAD:
            begin
                wbuf_shadow[c.tx_index] = c.tx_byte;
            end
            OP_START_WRITE, OP_START_READ:
            begin
                // a start while busy is dropped, timeout flag included
                if (!bus_claimed)
                begin
                    bus_claimed  = 1'b1;
                    dir_is_read  = (c.op == OP_START_READ);
                    addr_latched = c.slave_address;
                    timeout_seen = 1'b0;
                    r.start_cmd  = 1'b1;
                    if (c.op == OP_START_READ)
                    begin
                        if (c.read_count == '0)
                            bytes_wanted = CNT_ONE;
                        else if (c.read_count > RX_DEPTH_C)
                            bytes_wanted = RX_DEPTH_C;
                        else
                            bytes_wanted = c.read_count;
                    end
                end
            end
            OP_STATUS:
            begin
                if (c.arb_lost || c.status_kind == ST_OTHER)
                begin
                    fail = 1'b1;
                end
                else if (c.status_kind == ST_START_SENT)
                begin
                    // address byte goes out with the direction in bit 0
                    r.tx_valid = 1'b1;
                    r.tx_data  = (addr_latched & ADDR_MASK) | {7'b0, dir_is_read};
                    bytes_sent = CNT_ONE;
                    bytes_rcvd = CNT_ONE;
                end
                else if (c.status_kind == ST_BYTE_SENT)
                begin
                    if (c.ack_in)
                    begin
                        // in a read the ACK of the address needs no answer
                        if (!dir_is_read)
                        begin
                            len = (wr_len > TX_DEPTH_C) ? TX_DEPTH_C : wr_len;
                            if (bytes_sent >= CNT_ONE && bytes_sent <= len)
                            begin
                                r.tx_valid = 1'b1;
                                r.tx_data  = wbuf_shadow[TX_AW'(bytes_sent - CNT_ONE)];
                                bytes_sent = bytes_sent + CNT_ONE;
                            end
                            else
                            begin
                                r.stop_cmd  = 1'b1;
                                bus_claimed = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        // NACK: STOP then a fresh START, transfer stays open
                        r.stop_cmd  = 1'b1;
                        r.start_cmd = 1'b1;
                        err_tally   = err_tally + 32'd1;
                    end
                end
                else
                begin
                    r.rx_valid = 1'b1;
                    r.rx_index = 4'(bytes_rcvd - CNT_ONE);
                    r.rx_data  = c.rx_byte;
                    if (bytes_rcvd < bytes_wanted)
                    begin
                        r.ack_out  = 1'b1;
                        bytes_rcvd = bytes_rcvd + CNT_ONE;
                    end
                    else
                    begin
                        // last byte: NACK it and release the bus
                        r.stop_cmd  = 1'b1;
                        bus_claimed = 1'b0;
                    end
                end
                if (fail)
                begin
                    r.bus_reset = 1'b1;
                    bus_claimed = 1'b0;
                    err_tally   = err_tally + 32'd1;
                end
            end
            OP_TIMEOUT:
            begin
                r.bus_reset  = 1'b1;
                bus_claimed  = 1'b0;
                timeout_seen = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.busy_res    = bus_claimed;
        r.timed_out   = timeout_seen;
        r.error_count = err_tally;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders. Every field starts random so that fields the op does
    // not use still see both values on every bit.
    // ------------------------------------------------------------------
    function automatic cmd_item_t random_cmd(input logic [2:0] op);
        cmd_item_t c;
        c.op            = op;
        c.tx_index      = 4'($urandom);
        c.tx_byte       = 8'($urandom);
        c.slave_address = 8'($urandom);
        c.read_count    = 5'($urandom);
        c.status_kind   = 2'($urandom);
        c.ack_in        = 1'($urandom);
        c.arb_lost      = 1'($urandom);
        c.rx_byte       = 8'($urandom);
        return c;
    endfunction

    function automatic cmd_item_t status_ev(input logic [1:0] kind, input logic ack);
        cmd_item_t c;
        c             = random_cmd(OP_STATUS);
        c.status_kind = kind;
        c.ack_in      = ack;
        c.arb_lost    = 1'b0;
        return c;
    endfunction

    function automatic cmd_item_t start_ev(input logic [2:0] op, input logic [7:0] addr,
                                           input logic [4:0] count);
        cmd_item_t c;
        c               = random_cmd(op);
        c.slave_address = addr;
        c.read_count    = count;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // cmd side driver
    // ------------------------------------------------------------------
    task automatic drive_payload(input cmd_item_t c);
        cmd_bus.op            <= c.op;
        cmd_bus.tx_index      <= c.tx_index;
        cmd_bus.tx_byte       <= c.tx_byte;
        cmd_bus.slave_address <= c.slave_address;
        cmd_bus.read_count    <= c.read_count;
        cmd_bus.status_kind   <= c.status_kind;
        cmd_bus.ack_in        <= c.ack_in;
        cmd_bus.arb_lost      <= c.arb_lost;
        cmd_bus.rx_byte       <= c.rx_byte;
    endtask

    // One cmd transfer. valid is left high after acceptance so back-to-back
    // items never drop and raise it in the same step; it only falls ahead of
    // a gap, or when the stream pauses (see wait_all_results).
    task automatic send_cmd(input cmd_item_t c);
        int gap;
        gap = cmd_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        drive_payload(c);
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        awaited_outputs.push_back(bus_event_outputs(c));
        sent_items++;
    endtask

    // Stop the stream and let every queued result come back.
    task automatic wait_all_results();
        int guard;
        guard = 0;
        cmd_bus.valid <= 1'b0;
        while (awaited_outputs.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        if (awaited_outputs.size() != 0)
        begin
            $display("%0t: %0d expected results never came back", $time,
                     awaited_outputs.size());
            n_fail++;
            awaited_outputs.delete();
        end
    endtask

    // Register write, only with the block drained. Every op yields exactly
    // one result, so an empty queue means nothing is still in flight.
    task automatic set_write_length(input logic [CNT_W-1:0] len);
        wait_all_results();
        cfg_wdata <= len;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        wr_len    = len;
    endtask

    // ------------------------------------------------------------------
    // res side: random back-pressure and the checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            n_fail++;
        end
    endtask

    task automatic compare_outputs(input res_item_t want, input res_item_t got);
        check_field("tx_valid",    want.tx_valid,    got.tx_valid);
        check_field("tx_data",     want.tx_data,     got.tx_data);
        check_field("start_cmd",   want.start_cmd,   got.start_cmd);
        check_field("stop_cmd",    want.stop_cmd,    got.stop_cmd);
        check_field("ack_out",     want.ack_out,     got.ack_out);
        check_field("bus_reset",   want.bus_reset,   got.bus_reset);
        check_field("rx_valid",    want.rx_valid,    got.rx_valid);
        check_field("rx_index",    want.rx_index,    got.rx_index);
        check_field("rx_data",     want.rx_data,     got.rx_data);
        check_field("busy_res",    want.busy_res,    got.busy_res);
        check_field("timed_out",   want.timed_out,   got.timed_out);
        check_field("error_count", want.error_count, got.error_count);
    endtask

    initial
    begin : result_receiver
        int        stall;
        res_item_t got;
        res_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            // same rule as the cmd side: ready stays up across zero stalls
            stall = res_idle_on ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
            while (!res_bus.valid)
                @(posedge clk);
            got = {res_bus.tx_valid, res_bus.tx_data, res_bus.start_cmd, res_bus.stop_cmd,
                   res_bus.ack_out, res_bus.bus_reset, res_bus.rx_valid, res_bus.rx_index,
                   res_bus.rx_data, res_bus.busy_res, res_bus.timed_out,
                   res_bus.error_count};
            if (awaited_outputs.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %0h", $time, got);
                n_fail++;
            end
            else
                compare_outputs(awaited_outputs.pop_front(), got);
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Load every buffer slot, the extreme bytes at the two ends.
    task automatic test_buffer_fill();
        cmd_item_t c;
        for (int i = 0; i < TX_DEPTH; i++)
        begin
            c          = random_cmd(OP_LOAD);
            c.tx_index = 4'(i);
            if (i == 0)
                c.tx_byte = 8'h00;
            else if (i == TX_DEPTH - 1)
                c.tx_byte = 8'hFF;
            send_cmd(c);
        end
    endtask

    // Write of one byte (reset length) with a start while busy and a NACK.
    task automatic test_write_transfer();
        send_cmd(start_ev(OP_START_WRITE, 8'hFF, 5'($urandom)));
        send_cmd(start_ev(OP_START_READ, 8'h00, 5'($urandom)));   // dropped, busy
        send_cmd(status_ev(ST_START_SENT, 1'b1));                  // address, bit 0 clear
        send_cmd(status_ev(ST_BYTE_SENT, 1'b0));                   // NACK: STOP+START
        send_cmd(status_ev(ST_BYTE_SENT, 1'b1));                   // first data byte
        send_cmd(status_ev(ST_BYTE_SENT, 1'b1));                   // STOP, bus free
    endtask

    // Reads: count zero saturates to one, count above depth to the depth,
    // and an ACKed byte-sent during a read sends nothing.
    task automatic test_read_transfer();
        cmd_item_t c;
        send_cmd(start_ev(OP_START_READ, 8'h00, 5'd0));
        send_cmd(status_ev(ST_START_SENT, 1'b0));
        send_cmd(status_ev(ST_BYTE_SENT, 1'b1));
        c         = status_ev(ST_BYTE_RECV, 1'b1);
        c.rx_byte = 8'hFF;
        send_cmd(c);                                               // last byte, NACK+STOP
        send_cmd(start_ev(OP_START_READ, 8'h5A, 5'h1F));
        send_cmd(status_ev(ST_START_SENT, 1'b1));
        c         = status_ev(ST_BYTE_RECV, 1'b0);
        c.rx_byte = 8'h00;
        send_cmd(c);
        send_cmd(status_ev(ST_BYTE_RECV, 1'b1));
    endtask

    // Arbitration loss, unknown status, timeouts, events on an idle bus and
    // the unused op codes.
    task automatic test_faults_and_idle_events();
        cmd_item_t c;
        c             = status_ev(ST_BYTE_RECV, 1'b1);
        c.arb_lost    = 1'b1;
        send_cmd(c);                                               // aborts the open read
        send_cmd(status_ev(ST_OTHER, 1'b1));                       // idle bus, still an error
        send_cmd(random_cmd(OP_TIMEOUT));                          // idle timeout
        send_cmd(start_ev(OP_START_WRITE, 8'hA5, 5'($urandom)));   // clears timeout flag
        send_cmd(status_ev(ST_START_SENT, 1'b1));
        send_cmd(random_cmd(OP_TIMEOUT));                          // timeout mid transfer
        for (int k = OP_TIMEOUT + 1; k < OP_CODES; k++)
            send_cmd(random_cmd(3'(k)));
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed transfers with random content,
    // some broken by faults, plus loads and raw noise.
    // ------------------------------------------------------------------
    task automatic disrupt_transfer();
        cmd_item_t c;
        case ($urandom_range(0, 4))
            0:
            begin
                // NACK, then the retried START comes back and restarts counts
                send_cmd(status_ev(ST_BYTE_SENT, 1'b0));
                send_cmd(status_ev(ST_START_SENT, 1'($urandom)));
            end
            1:
            begin
                c          = random_cmd(OP_STATUS);
                c.arb_lost = 1'b1;
                send_cmd(c);
            end
            2:
                send_cmd(status_ev(ST_OTHER, 1'($urandom)));
            3:
                send_cmd(random_cmd(OP_TIMEOUT));
            default:
                send_cmd(random_cmd($urandom_range(0, 1) ? OP_START_WRITE : OP_START_READ));
        endcase
    endtask

    task automatic write_sequence();
        int guard;
        guard = 0;
        send_cmd(start_ev(OP_START_WRITE, 8'($urandom), 5'($urandom)));
        send_cmd(status_ev(ST_START_SENT, 1'($urandom)));
        while (bus_claimed && !dir_is_read && guard < 40)
        begin
            if ($urandom_range(0, 19) == 0)
                disrupt_transfer();
            else
                send_cmd(status_ev(ST_BYTE_SENT, 1'b1));
            guard++;
        end
    endtask

    task automatic read_sequence();
        int               guard;
        int               pick;
        logic [CNT_W-1:0] count;
        guard = 0;
        // mostly legal counts, now and then the whole field incl. 0 and > depth
        if ($urandom_range(0, 4) == 0)
            count = CNT_W'($urandom);
        else
            count = CNT_W'($urandom_range(1, RX_DEPTH));
        send_cmd(start_ev(OP_START_READ, 8'($urandom), count));
        send_cmd(status_ev(ST_START_SENT, 1'($urandom)));
        while (bus_claimed && dir_is_read && guard < 40)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                disrupt_transfer();
            else if (pick == 1)
                send_cmd(status_ev(ST_BYTE_SENT, 1'b1));
            else
                send_cmd(status_ev(ST_BYTE_RECV, 1'($urandom)));
            guard++;
        end
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            write_sequence();
        else if (pick < 75)
            read_sequence();
        else if (pick < 85)
            repeat ($urandom_range(1, 3)) send_cmd(random_cmd(OP_LOAD));
        else
            send_cmd(random_cmd(3'($urandom)));    // any op, any field
    endtask

    // Ten phases; each one drains the block, writes a new length and picks
    // which side idles. First the extremes: zero, the depth, all ones, one.
    task automatic test_random_traffic();
        logic [CNT_W-1:0] len;
        int               phase_end;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:       len = '0;
                1:       len = TX_DEPTH_C;
                2:       len = '1;
                3:       len = CNT_ONE;
                default: len = CNT_W'($urandom_range(0, 31));
            endcase
            set_write_length(len);
            cmd_idle_on = (ph % 4 == 0) || (ph % 4 == 2);
            res_idle_on = (ph % 4 == 0) || (ph % 4 == 1);
            phase_end   = sent_items + 140;
            while (sent_items < phase_end)
                random_sequence();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= CNT_ONE;
        cmd_bus.valid <= 1'b0;
        drive_payload('0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_buffer_fill();
        test_write_transfer();
        test_read_transfer();
        test_faults_and_idle_events();
        test_random_traffic();

        // drain, then stay quiet to catch any stray result
        wait_all_results();
        repeat (8) @(posedge clk);
        if (n_fail == 0)
            $display("[smbus_master_transfer_sequencer] OK");
        else
            $display("[smbus_master_transfer_sequencer] ERROR");
        $finish;
    end

    // Watchdog, far past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("[smbus_master_transfer_sequencer] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
